// File: rtl/lr_pkg.sv
`default_nettype none

package lr_pkg;

    // Request kind carried in the input tuser bit.
    typedef enum logic
    {
        OP_START = 1'b0,
        OP_NEXT  = 1'b1
    } op_t;

    localparam int unsigned COLOR_BITS = 8;

    // Control from the request stage to the line walker.
    typedef struct packed
    {
        logic start;   // load a new line from the setup logic
        logic step;    // emit the current pixel and advance
    } lr_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/lr_setup.sv
`default_nettype none

module lr_setup #(
    parameter int unsigned COORD_BITS = 11
) (
    input  wire logic [COORD_BITS-1:0] x_a,
    input  wire logic [COORD_BITS-1:0] y_a,
    input  wire logic [COORD_BITS-1:0] x_b,
    input  wire logic [COORD_BITS-1:0] y_b,
    output logic                       y_is_major,
    output logic [COORD_BITS-1:0]      major_start,
    output logic [COORD_BITS-1:0]      major_end,
    output logic [COORD_BITS-1:0]      minor_start,
    output logic                       minor_descending,
    output logic [COORD_BITS-1:0]      major_span,
    output logic [COORD_BITS-1:0]      minor_span,
    output logic [COORD_BITS+1:0]      error_init
);

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] ma;
    logic [COORD_BITS-1:0] mb;
    logic [COORD_BITS-1:0] na;
    logic [COORD_BITS-1:0] nb;
    logic [COORD_BITS-1:0] minor_end;

    always_comb
    begin
        dx = (x_a > x_b) ? (x_a - x_b) : (x_b - x_a);
        dy = (y_a > y_b) ? (y_a - y_b) : (y_b - y_a);
        y_is_major = (dy > dx);

        if (y_is_major)
        begin
            ma = y_a;
            mb = y_b;
            na = x_a;
            nb = x_b;
        end
        else
        begin
            ma = x_a;
            mb = x_b;
            na = y_a;
            nb = y_b;
        end

        // Order the endpoints so the major coordinate rises.
        if (ma > mb)
        begin
            major_start = mb;
            major_end   = ma;
            minor_start = nb;
            minor_end   = na;
        end
        else
        begin
            major_start = ma;
            major_end   = mb;
            minor_start = na;
            minor_end   = nb;
        end

        minor_descending = (minor_end < minor_start);
        major_span = major_end - major_start;
        minor_span = minor_descending ? (minor_start - minor_end) : (minor_end - minor_start);

        // Bias by one on a falling minor axis so ties round up in both directions.
        if (major_span == '0)
            error_init = '0;
        else if (minor_descending)
            error_init = {2'b00, major_span - 1'b1};
        else
            error_init = {2'b00, major_span};
    end

endmodule

`default_nettype wire

// File: rtl/lr_walker.sv
`default_nettype none

module lr_walker #(
    parameter int unsigned COORD_BITS = 11
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire lr_pkg::lr_ctrl_t          ctrl,
    input  wire logic                      set_y_is_major,
    input  wire logic [COORD_BITS-1:0]     set_major_start,
    input  wire logic [COORD_BITS-1:0]     set_major_end,
    input  wire logic [COORD_BITS-1:0]     set_minor_start,
    input  wire logic                      set_minor_descending,
    input  wire logic [COORD_BITS-1:0]     set_major_span,
    input  wire logic [COORD_BITS-1:0]     set_minor_span,
    input  wire logic [COORD_BITS+1:0]     set_error_init,
    input  wire logic [3*lr_pkg::COLOR_BITS-1:0] set_color,
    output logic                           busy,
    output logic [COORD_BITS-1:0]          pixel_x,
    output logic [COORD_BITS-1:0]          pixel_y,
    output logic [3*lr_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                           pixel_last
);

    import lr_pkg::*;

    localparam int unsigned ERR_BITS = COORD_BITS + 2;

    logic                        busy_reg;
    logic                        busy_next;
    logic                        y_major_reg;
    logic [COORD_BITS-1:0]       major_pos_reg;
    logic [COORD_BITS-1:0]       major_pos_next;
    logic [COORD_BITS-1:0]       major_end_reg;
    logic [COORD_BITS-1:0]       minor_pos_reg;
    logic [COORD_BITS-1:0]       minor_pos_next;
    logic                        minor_desc_reg;
    logic [COORD_BITS-1:0]       major_span_reg;
    logic [COORD_BITS-1:0]       minor_span_reg;
    logic [ERR_BITS-1:0]         err_reg;
    logic [ERR_BITS-1:0]         err_next;
    logic [3*COLOR_BITS-1:0]     color_reg;
    logic [ERR_BITS-1:0]         err_sum;
    logic [ERR_BITS-1:0]         major_twice;
    logic                        at_end;

    always_comb
    begin
        at_end      = (major_pos_reg == major_end_reg);
        major_twice = {1'b0, major_span_reg, 1'b0};
        err_sum     = err_reg + {1'b0, minor_span_reg, 1'b0};

        busy_next      = busy_reg;
        major_pos_next = major_pos_reg;
        minor_pos_next = minor_pos_reg;
        err_next       = err_reg;

        if (ctrl.start)
        begin
            busy_next      = 1'b1;
            major_pos_next = set_major_start;
            minor_pos_next = set_minor_start;
            err_next       = set_error_init;
        end
        else if (ctrl.step)
        begin
            if (at_end)
                busy_next = 1'b0;
            else
            begin
                major_pos_next = major_pos_reg + 1'b1;
                if (err_sum >= major_twice)
                begin
                    err_next       = err_sum - major_twice;
                    minor_pos_next = minor_desc_reg ? (minor_pos_reg - 1'b1)
                                                    : (minor_pos_reg + 1'b1);
                end
                else
                    err_next = err_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        major_pos_reg <= major_pos_next;
        minor_pos_reg <= minor_pos_next;
        err_reg       <= err_next;
        if (ctrl.start)
        begin
            y_major_reg    <= set_y_is_major;
            major_end_reg  <= set_major_end;
            minor_desc_reg <= set_minor_descending;
            major_span_reg <= set_major_span;
            minor_span_reg <= set_minor_span;
            color_reg      <= set_color;
        end
    end

    assign busy        = busy_reg;
    assign pixel_x     = y_major_reg ? minor_pos_reg : major_pos_reg;
    assign pixel_y     = y_major_reg ? major_pos_reg : minor_pos_reg;
    assign pixel_color = color_reg;
    assign pixel_last  = at_end;

    // The scaled remainder stays below twice the major span on any running line.
    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (major_span_reg != '0) |-> (err_reg < major_twice))
        else $error("error term out of range");

    // The walk never runs past the far endpoint.
    a_major_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (major_pos_reg <= major_end_reg))
        else $error("major position past line end");

endmodule

`default_nettype wire

// File: rtl/line_rasterizer.sv
`default_nettype none
// Channel   | Direction | Signals                        | Contents
// ----------+-----------+--------------------------------+---------------------------------
// s_axis    | in        | tvalid tready tdata tuser      | start or next-pixel request
// m_axis    | out       | tvalid tready tdata tlast      | one pixel, tlast on final pixel
//
// One request per cycle sustained while m_axis accepts; the s_axis handshake loads the input
// register, and a step then loads the pixel into the output register that drives m_axis.
// The walker does one error-term add and compare per pixel, which sets the pace.
// A start request yields no pixel; a next-pixel request while idle is dropped.
// rst_n clears both valid flags and the line-active flag; payload is not reset.
// Output stall: the input register holds while a pixel request waits for room,
// and s_axis_tready drops only then.

module line_rasterizer #(
    parameter int unsigned COORD_BITS = 11
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // low to high: x_a, y_a, x_b, y_b, red, green, blue, zero fill
    input  wire logic [((4*COORD_BITS+3*lr_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  wire logic [0:0] s_axis_tuser,

    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // low to high: pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, zero fill
    output logic [((2*COORD_BITS+3*lr_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    // last
    output logic      m_axis_tlast
);

    import lr_pkg::*;

    localparam int unsigned IN_USED  = 4*COORD_BITS + 3*COLOR_BITS;
    localparam int unsigned OUT_USED = 2*COORD_BITS + 3*COLOR_BITS;
    localparam int unsigned OUT_W    = ((OUT_USED + 7) / 8) * 8;
    localparam int unsigned C        = COORD_BITS;

    // Input register.
    logic                 in_valid_reg;
    logic                 in_valid_next;
    op_t                  in_op_reg;
    logic [IN_USED-1:0]   in_data_reg;

    // Output register.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [OUT_USED-1:0]  out_data_reg;
    logic                 out_last_reg;

    logic                 s_fire;
    logic                 out_free;
    logic                 needs_out;
    logic                 in_fire;
    lr_ctrl_t             ctrl;

    logic                 su_y_is_major;
    logic [C-1:0]         su_major_start;
    logic [C-1:0]         su_major_end;
    logic [C-1:0]         su_minor_start;
    logic                 su_minor_descending;
    logic [C-1:0]         su_major_span;
    logic [C-1:0]         su_minor_span;
    logic [C+1:0]         su_error_init;

    logic                 walk_busy;
    logic [C-1:0]         pix_x;
    logic [C-1:0]         pix_y;
    logic [3*COLOR_BITS-1:0] pix_color;
    logic                 pix_last;

    // Retire the held request when it makes no pixel or the output register has room.
    always_comb
    begin
        out_free   = !out_valid_reg || m_axis_tready;
        needs_out  = (in_op_reg == OP_NEXT) && walk_busy;
        in_fire    = in_valid_reg && (!needs_out || out_free);
        ctrl.start = in_fire && (in_op_reg == OP_START);
        ctrl.step  = in_fire && needs_out;

        s_axis_tready = !in_valid_reg || in_fire;
        s_fire        = s_axis_tvalid && s_axis_tready;

        in_valid_next = s_fire ? 1'b1 : (in_fire ? 1'b0 : in_valid_reg);

        if (ctrl.step)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request; load the pixel on each step.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_op_reg   <= op_t'(s_axis_tuser[0]);
            in_data_reg <= s_axis_tdata[IN_USED-1:0];
        end
        if (ctrl.step)
        begin
            out_data_reg <= {pix_color, pix_y, pix_x};
            out_last_reg <= pix_last;
        end
    end

    lr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .x_a              (in_data_reg[C-1:0]),
        .y_a              (in_data_reg[2*C-1:C]),
        .x_b              (in_data_reg[3*C-1:2*C]),
        .y_b              (in_data_reg[4*C-1:3*C]),
        .y_is_major       (su_y_is_major),
        .major_start      (su_major_start),
        .major_end        (su_major_end),
        .minor_start      (su_minor_start),
        .minor_descending (su_minor_descending),
        .major_span       (su_major_span),
        .minor_span       (su_minor_span),
        .error_init       (su_error_init)
    );

    // Color passes through as received: red in the low byte, blue in the high byte.
    lr_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .ctrl                 (ctrl),
        .set_y_is_major       (su_y_is_major),
        .set_major_start      (su_major_start),
        .set_major_end        (su_major_end),
        .set_minor_start      (su_minor_start),
        .set_minor_descending (su_minor_descending),
        .set_major_span       (su_major_span),
        .set_minor_span       (su_minor_span),
        .set_error_init       (su_error_init),
        .set_color            (in_data_reg[IN_USED-1:4*C]),
        .busy                 (walk_busy),
        .pixel_x              (pix_x),
        .pixel_y              (pix_y),
        .pixel_color          (pix_color),
        .pixel_last           (pix_last)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-OUT_USED){1'b0}}, out_data_reg};
    assign m_axis_tlast  = out_last_reg;

    // A held request that cannot retire stays in the input register.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_fire |=> in_valid_reg)
        else $error("input request lost while stalled");

    // The final pixel ends the line.
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step && pix_last |=> !walk_busy)
        else $error("line still active after final pixel");

    // A pixel waiting for the sink is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !ctrl.step)
        else $error("pixel overwritten while stalled");

endmodule

`default_nettype wire
